@@ rtl/alfr_pkg.sv @@
// alfr_pkg: shared widths, action codes, control structs and the seed table
// for the additive lagged-Fibonacci generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alfr_pkg;

    localparam int WORD_W     = 32;
    localparam int RAND_W     = 53;
    localparam int IDX_W      = 5;
    localparam int ACT_W      = 3;
    localparam int SEED_COUNT = 31;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_DRAW      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_WORD = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET_POS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ_WORD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_POS  = 3'd4;

    // Per-cycle command to every cell of the chain
    typedef struct packed {
        logic shift_one;   // rotate the chain by one place
        logic shift_two;   // advance the chain by two places after a draw
    } alfr_cell_ctrl_t;

    // Status from the position sequencer
    typedef struct packed {
        logic busy;
        logic rotate;
    } alfr_seq_stat_t;

    localparam logic [WORD_W-1:0] RESET_WORDS [SEED_COUNT] = '{
        32'h90399a31, 32'hc02432d9, 32'h31829b66, 32'hf3425da1,
        32'h81e0de3b, 32'h6fb5df0a, 32'hbc02f103, 32'h40fb48f3,
        32'he56b7449, 32'hdbb0beb1, 32'h5918ab5c, 32'h54fd9465,
        32'h680f8c2e, 32'h799feb3d, 32'he0b7b11e, 32'h6b862d43,
        32'h2e2ada67, 32'hca881588, 32'h735de369, 32'h35f7904f,
        32'h8fd6d715, 32'hf0516fa6, 32'h6b96616e, 32'hefdcac94,
        32'h3f933641, 32'hc298c622, 32'h2ab8f5a4, 32'hd77b8a88,
        32'h9d0ef5ad, 32'h220b8999, 32'h47b927fb
    };

    // Reset word of table entry i; entries past the seed list start at zero
    function automatic logic [WORD_W-1:0] seed_word(input int unsigned i);
        logic [WORD_W-1:0] w;
        w = '0;
        if (i < SEED_COUNT) w = RESET_WORDS[i];
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/alfr_if.sv @@
// alfr_cmd_if and alfr_rsp_if: valid/ready channels for command beats and
// result beats. Depends on alfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface alfr_cmd_if;
    import alfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [IDX_W-1:0]    word_index;
    logic [WORD_W-1:0]   data_in;

    modport source (output valid, action, word_index, data_in, input ready);
    modport sink   (input valid, action, word_index, data_in, output ready);
endinterface

interface alfr_rsp_if;
    import alfr_pkg::*;

    logic                valid;
    logic                ready;
    logic [RAND_W-1:0]   random_bits;
    logic [WORD_W-1:0]   read_word;

    modport source (output valid, random_bits, read_word, input ready);
    modport sink   (input valid, random_bits, read_word, output ready);
endinterface

`default_nettype wire

@@ rtl/alfr_cell.sv @@
// alfr_cell: one table word of the lag chain; holds, takes its neighbor's
// word, takes the word two places on, or loads a written word. Uses alfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alfr_cell #(
    parameter logic [alfr_pkg::WORD_W-1:0] SEED = '0
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  alfr_pkg::alfr_cell_ctrl_t   ctrl,
    input  wire                               wr_en,
    input  wire  [alfr_pkg::WORD_W-1:0]       wr_data,
    input  wire  [alfr_pkg::WORD_W-1:0]       near_word,
    input  wire  [alfr_pkg::WORD_W-1:0]       far_word,
    output logic [alfr_pkg::WORD_W-1:0]       word
);
    import alfr_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Select the next word: write, advance two, rotate one, or hold
    always_comb
    begin
        word_next = word_reg;
        if (wr_en)
        begin
            word_next = wr_data;
        end
        else if (ctrl.shift_two)
        begin
            word_next = far_word;
        end
        else if (ctrl.shift_one)
        begin
            word_next = near_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= SEED;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

@@ rtl/alfr_pos_seq.sv @@
// alfr_pos_seq: reduces a new position modulo the table size by a reciprocal
// multiply in ST_MUL and ST_REM, then steps the chain by one place a cycle
// until it is aligned. Uses alfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alfr_pos_seq #(
    parameter int TABLE_WORDS = 31
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    input  wire  [alfr_pkg::WORD_W-1:0]           data_in,
    input  wire  [$clog2(TABLE_WORDS)-1:0]        front,
    output alfr_pkg::alfr_seq_stat_t              stat
);
    import alfr_pkg::*;

    localparam int PW     = $clog2(TABLE_WORDS);
    localparam int SH     = WORD_W + PW;
    localparam int PROD_W = 2 * WORD_W + 1;
    localparam int QUOT_W = PROD_W - SH;

    // Reciprocal of the table size scaled by 2^SH, rounded up; exact quotient
    // for every 32-bit dividend
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(TABLE_WORDS - 1)) / 64'(TABLE_WORDS);
    localparam logic [WORD_W:0] RECIP = RECIP_FULL[WORD_W:0];

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_ROT  = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [WORD_W-1:0]    bits_reg;
    logic [WORD_W-1:0]    bits_next;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W-1:0]    prod_next;
    logic [PW-1:0]        rem_reg;
    logic [PW-1:0]        rem_next;
    logic [QUOT_W-1:0]    quot;

    // Quotient of the captured position by the table size
    assign quot = prod_reg[PROD_W-1:SH];

    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                    bits_next  = data_in;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(bits_reg) * PROD_W'(RECIP);
                state_next = ST_REM;
            end
            ST_REM:
            begin
                // Remainder is below the table size, so its low bits suffice
                rem_next   = bits_reg[PW-1:0] - quot[PW-1:0] * PW'(TABLE_WORDS);
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (front == rem_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy   = (state_reg != ST_IDLE);
    assign stat.rotate = (state_reg == ST_ROT) && (front != rem_reg);

endmodule

`default_nettype wire

@@ rtl/additive_lagged_fibonacci_rng.sv @@
// Channel  Dir  Payload                          Notes
// cmd      in   action, word_index, data_in      one beat per action
// rsp      out  random_bits, read_word           one beat per accepted cmd beat
//
// A draw per cycle is sustained while neither a set position nor a full skid
// entry holds cmd off, the two lag adders sitting in front of a chain of word
// cells. Set position holds cmd off after its beat while the remainder is
// formed by reciprocal multiply, then the chain rotates one place a cycle
// until it is seen aligned.
// Reset loads the seed words into the cells at once; no clearing pass.
// A two-entry output buffer keeps cmd open while one rsp beat is stalled.
//
// Top level of the additive lagged-Fibonacci generator.
// Depends on alfr_pkg, alfr_if, alfr_cell and alfr_pos_seq.
`timescale 1ns / 1ps
`default_nettype none

module additive_lagged_fibonacci_rng #(
    parameter int TABLE_WORDS    = 31,
    parameter int LAG_SEPARATION = 3
) (
    input  wire          clk,
    input  wire          rst_n,
    alfr_cmd_if.sink     cmd,
    alfr_rsp_if.source   rsp
);
    import alfr_pkg::*;

    localparam int PW   = $clog2(TABLE_WORDS);
    localparam int AW   = ((PW > IDX_W) ? PW : IDX_W) + 1;
    localparam int LAG  = LAG_SEPARATION % TABLE_WORDS;
    localparam int IDX2 = (1 + LAG) % TABLE_WORDS;

    logic [WORD_W-1:0]  cell_word [TABLE_WORDS];
    alfr_cell_ctrl_t    cell_ctrl;
    alfr_seq_stat_t     seq_stat;

    logic [PW-1:0]      front_reg;
    logic [PW-1:0]      front_next;
    logic [PW:0]        front_inc1;
    logic [PW:0]        front_inc2;
    logic [PW-1:0]      front_adv1;
    logic [PW-1:0]      front_adv2;

    logic               cmd_fire;
    logic               rsp_fire;
    logic               is_draw;
    logic               is_write;

    logic [WORD_W-1:0]  sum1;
    logic [WORD_W-1:0]  sum2;
    logic [WORD_W-1:0]  sum2_rhs;

    logic [AW-1:0]      idx_ext;
    logic [AW-1:0]      rel_raw;
    logic [AW-1:0]      rel_mod;
    logic [PW-1:0]      rel_idx;
    logic               idx_ok;

    logic [RAND_W-1:0]  res_bits;
    logic [WORD_W-1:0]  res_word;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic               load_out;
    logic               load_skid;
    logic               move_skid;
    logic [RAND_W-1:0]  out_bits_reg;
    logic [WORD_W-1:0]  out_word_reg;
    logic [RAND_W-1:0]  skid_bits_reg;
    logic [WORD_W-1:0]  skid_word_reg;

    // Handshake
    assign cmd.ready = !seq_stat.busy && !skid_valid_reg;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp_fire  = out_valid_reg && rsp.ready;
    assign is_draw   = cmd_fire && (cmd.action == ACT_DRAW);
    assign is_write  = cmd_fire && (cmd.action == ACT_WRITE_WORD) && idx_ok;

    // Two lag steps; cell 0 always holds the word at the front pointer
    assign sum1     = cell_word[0] + cell_word[LAG];
    assign sum2_rhs = (IDX2 == 0) ? sum1 : cell_word[IDX2];
    assign sum2     = cell_word[1] + sum2_rhs;

    // Map an absolute table index onto its cell
    assign idx_ext = AW'(cmd.word_index);
    assign idx_ok  = idx_ext < AW'(TABLE_WORDS);
    assign rel_raw = idx_ext + AW'(TABLE_WORDS) - AW'(front_reg);
    assign rel_mod = (rel_raw >= AW'(TABLE_WORDS)) ? rel_raw - AW'(TABLE_WORDS) : rel_raw;
    assign rel_idx = rel_mod[PW-1:0];

    assign cell_ctrl.shift_two = is_draw;
    assign cell_ctrl.shift_one = seq_stat.rotate;

    // Chain of cells: neighbor one place on for rotation, two places on for a
    // draw, with the two new sums entering at the tail
    for (genvar i = 0; i < TABLE_WORDS; i++)
    begin : g_cell
        logic [WORD_W-1:0] near_word;
        logic [WORD_W-1:0] far_word;

        if (i == TABLE_WORDS - 1)
        begin : g_tail
            assign near_word = cell_word[0];
            assign far_word  = sum2;
        end
        else if (i == TABLE_WORDS - 2)
        begin : g_pre_tail
            assign near_word = cell_word[i+1];
            assign far_word  = sum1;
        end
        else
        begin : g_body
            assign near_word = cell_word[i+1];
            assign far_word  = cell_word[i+2];
        end

        alfr_cell #(
            .SEED (seed_word(i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .wr_en     (is_write && (rel_idx == PW'(i))),
            .wr_data   (cmd.data_in),
            .near_word (near_word),
            .far_word  (far_word),
            .word      (cell_word[i])
        );
    end

    alfr_pos_seq #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_pos_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd_fire && (cmd.action == ACT_SET_POS)),
        .data_in (cmd.data_in),
        .front   (front_reg),
        .stat    (seq_stat)
    );

    // Advance the front pointer by one or two places, wrapping at the table size
    assign front_inc1 = (PW+1)'(front_reg) + (PW+1)'(1);
    assign front_inc2 = (PW+1)'(front_reg) + (PW+1)'(2);
    assign front_adv1 = (front_inc1 >= (PW+1)'(TABLE_WORDS))
                        ? PW'(front_inc1 - (PW+1)'(TABLE_WORDS)) : front_inc1[PW-1:0];
    assign front_adv2 = (front_inc2 >= (PW+1)'(TABLE_WORDS))
                        ? PW'(front_inc2 - (PW+1)'(TABLE_WORDS)) : front_inc2[PW-1:0];

    always_comb
    begin
        front_next = front_reg;
        if (is_draw)
        begin
            front_next = front_adv2;
        end
        else if (seq_stat.rotate)
        begin
            front_next = front_adv1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    // Form the result beat of the accepted action
    always_comb
    begin
        res_bits = '0;
        res_word = '0;
        case (cmd.action)
            ACT_DRAW:
            begin
                res_bits = {sum1, 1'b0, sum2[WORD_W-1:12]};
            end
            ACT_READ_WORD:
            begin
                if (idx_ok) res_word = cell_word[rel_idx];
            end
            ACT_READ_POS:
            begin
                res_word = WORD_W'(front_reg);
            end
            default:
            begin
                res_word = '0;
            end
        endcase
    end

    // Output register with a skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        move_skid       = 1'b0;
        if (rsp_fire)
        begin
            if (skid_valid_reg)
            begin
                move_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (cmd_fire)
        begin
            if (!out_valid_reg || rsp_fire)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_bits_reg <= res_bits;
            out_word_reg <= res_word;
        end
        else if (move_skid)
        begin
            out_bits_reg <= skid_bits_reg;
            out_word_reg <= skid_word_reg;
        end
        if (load_skid)
        begin
            skid_bits_reg <= res_bits;
            skid_word_reg <= res_word;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_bits = out_bits_reg;
    assign rsp.read_word   = out_word_reg;

    // The skid entry is only ever filled behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a valid output beat");

    // The front pointer stays inside the table
    a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
        (PW+1)'(front_reg) < (PW+1)'(TABLE_WORDS))
        else $error("front pointer outside the table");

    // A set-position beat holds off cmd while the sequencer works
    a_setpos_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.action == ACT_SET_POS)) |=> (seq_stat.busy && !cmd.ready))
        else $error("sequencer idle after a set-position beat");

    // Rotation never overlaps a draw
    a_rotate_no_draw: assert property (@(posedge clk) disable iff (!rst_n)
        seq_stat.rotate |-> (seq_stat.busy && !cmd_fire))
        else $error("chain rotation while a command beat is taken");

endmodule

`default_nettype wire
